### rtl/core/cos2x_pkg.sv
// Shared types and constants for the cosine-squared crossfader.
`timescale 1ns / 1ps

package cos2x_pkg;

    // Coefficient format: unsigned Q0.16
    localparam int COEF_BITS = 16;

    // Per-beat control bits that travel down the pipeline with the samples
    typedef struct packed {
        logic valid;
        logic fading;
        logic done;
    } ctl_t;

endpackage

### rtl/core/cos2x_ctrl.sv
// Fade sequencer: lane selection, progress tracking and coefficient ROM (stage 1).
`timescale 1ns / 1ps

module cos2x_ctrl #(
    parameter int BLOCK_SAMPLES    = 128,
    parameter int COEF_TABLE_DEPTH = 256,
    parameter int SAMPLE_BITS      = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic                                  in_op,
    input  logic [1:0]                            in_policy,
    input  logic signed [SAMPLE_BITS-1:0]         in_a,
    input  logic signed [SAMPLE_BITS-1:0]         in_b,
    output cos2x_pkg::ctl_t                       st1,
    output logic signed [SAMPLE_BITS-1:0]         live1,
    output logic signed [SAMPLE_BITS-1:0]         other1,
    output logic [cos2x_pkg::COEF_BITS-1:0]       coef1
);
    import cos2x_pkg::*;

    // Widths
    localparam int LW = $clog2(8 * BLOCK_SAMPLES + 1);
    localparam int AW = (COEF_TABLE_DEPTH > 1) ? $clog2(COEF_TABLE_DEPTH) : 1;
    localparam int IW = AW + 1;

    // Fade lengths in samples
    localparam logic [LW-1:0] LEN2 = LW'(2 * BLOCK_SAMPLES);
    localparam logic [LW-1:0] LEN4 = LW'(4 * BLOCK_SAMPLES);
    localparam logic [LW-1:0] LEN8 = LW'(8 * BLOCK_SAMPLES);

    // Table index step per sample: DEPTH / length as quotient and remainder
    localparam logic [IW-1:0] DQ2 = IW'(COEF_TABLE_DEPTH / (2 * BLOCK_SAMPLES));
    localparam logic [IW-1:0] DQ4 = IW'(COEF_TABLE_DEPTH / (4 * BLOCK_SAMPLES));
    localparam logic [IW-1:0] DQ8 = IW'(COEF_TABLE_DEPTH / (8 * BLOCK_SAMPLES));
    localparam logic [LW-1:0] DR2 = LW'(COEF_TABLE_DEPTH % (2 * BLOCK_SAMPLES));
    localparam logic [LW-1:0] DR4 = LW'(COEF_TABLE_DEPTH % (4 * BLOCK_SAMPLES));
    localparam logic [LW-1:0] DR8 = LW'(COEF_TABLE_DEPTH % (8 * BLOCK_SAMPLES));

    localparam logic [IW-1:0] IDX_END  = IW'(COEF_TABLE_DEPTH);
    localparam logic [AW-1:0] IDX_LAST = AW'(COEF_TABLE_DEPTH - 1);

    // Opcodes and policy codes
    localparam logic       OP_SAMPLE = 1'b0;
    localparam logic       OP_START  = 1'b1;
    localparam logic [1:0] POL_4BLK  = 2'd1;
    localparam logic [1:0] POL_8BLK  = 2'd2;

    typedef enum logic [1:0] {
        LEN_2BLK,
        LEN_4BLK,
        LEN_8BLK
    } len_code_t;

    typedef logic [COEF_BITS-1:0] rom_t [COEF_TABLE_DEPTH];

    // cos^2 of (pi/2 * k / DEPTH) in Q0.16, Q2.30 Taylor evaluation
    function automatic logic [COEF_BITS-1:0] cos2_entry(input int unsigned k);
        logic [63:0] theta;
        logic [63:0] x2;
        logic [63:0] r;
        logic [63:0] t;
        logic [63:0] c;
        theta = (64'(k) * 64'd1686629713) / COEF_TABLE_DEPTH;
        x2    = (theta * theta) >> 30;
        r     = 64'd1 << 30;
        for (int i = 0; i < 6; i++) begin
            unique case (i)
                0:       t = ((x2 * r) >> 30) / 64'd132;
                1:       t = ((x2 * r) >> 30) / 64'd90;
                2:       t = ((x2 * r) >> 30) / 64'd56;
                3:       t = ((x2 * r) >> 30) / 64'd30;
                4:       t = ((x2 * r) >> 30) / 64'd12;
                default: t = ((x2 * r) >> 30) >> 1;
            endcase
            if (t > (64'd1 << 30)) begin
                t = 64'd1 << 30;
            end
            r = (64'd1 << 30) - t;
        end
        c = (((r * r) >> 30) + (64'd1 << 13)) >> 14;
        if (c > 64'd65535) begin
            c = 64'd65535;
        end
        return c[COEF_BITS-1:0];
    endfunction

    function automatic rom_t build_rom();
        rom_t rom;
        for (int k = 0; k < COEF_TABLE_DEPTH; k++) begin
            rom[k] = cos2_entry(k);
        end
        return rom;
    endfunction

    localparam rom_t COEF_ROM = build_rom();

    // Fade state
    logic                 live_lane_reg,  live_lane_next;
    logic                 active_reg,     active_next;
    logic [LW-1:0]        progress_reg,   progress_next;
    len_code_t            len_code_reg,   len_code_next;
    logic [IW-1:0]        idx_reg,        idx_next;
    logic [LW-1:0]        rem_reg,        rem_next;

    // Stage 1 registers
    ctl_t                          st1_reg,    st1_next;
    logic signed [SAMPLE_BITS-1:0] live1_reg,  other1_reg;
    logic [COEF_BITS-1:0]          coef1_reg;

    logic [LW-1:0] fade_len;
    logic [IW-1:0] step_q;
    logic [LW-1:0] step_r;
    logic [LW:0]   rem_sum;
    logic [LW-1:0] prog_inc;
    logic [AW-1:0] rd_addr;
    logic          take;

    // Decode stored length code
    always_comb begin
        unique case (len_code_reg)
            LEN_4BLK: begin fade_len = LEN4; step_q = DQ4; step_r = DR4; end
            LEN_8BLK: begin fade_len = LEN8; step_q = DQ8; step_r = DR8; end
            default:  begin fade_len = LEN2; step_q = DQ2; step_r = DR2; end
        endcase
    end

    assign take     = en && in_valid;
    assign rem_sum  = {1'b0, rem_reg} + {1'b0, step_r};
    assign prog_inc = progress_reg + LW'(1);
    assign rd_addr  = (idx_reg >= IDX_END) ? IDX_LAST : idx_reg[AW-1:0];

    // Next-state for the fade sequencer
    always_comb begin
        live_lane_next = live_lane_reg;
        active_next    = active_reg;
        progress_next  = progress_reg;
        len_code_next  = len_code_reg;
        idx_next       = idx_reg;
        rem_next       = rem_reg;
        st1_next       = '0;
        if (take) begin
            if (in_op == OP_START) begin
                unique case (in_policy)
                    POL_4BLK: len_code_next = LEN_4BLK;
                    POL_8BLK: len_code_next = LEN_8BLK;
                    default:  len_code_next = LEN_2BLK;
                endcase
                progress_next = '0;
                idx_next      = '0;
                rem_next      = '0;
                active_next   = 1'b1;
            end else if (in_op == OP_SAMPLE) begin
                st1_next.valid = 1'b1;
                if (active_reg) begin
                    st1_next.fading = 1'b1;
                    progress_next   = prog_inc;
                    // index tracks floor(progress * DEPTH / length)
                    if (rem_sum >= {1'b0, fade_len}) begin
                        rem_next = LW'(rem_sum - {1'b0, fade_len});
                        idx_next = idx_reg + step_q + IW'(1);
                    end else begin
                        rem_next = rem_sum[LW-1:0];
                        idx_next = idx_reg + step_q;
                    end
                    if (prog_inc >= fade_len) begin
                        st1_next.done  = 1'b1;
                        active_next    = 1'b0;
                        live_lane_next = ~live_lane_reg;
                    end
                end
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_lane_reg <= 1'b0;
            active_reg    <= 1'b0;
            progress_reg  <= '0;
            len_code_reg  <= LEN_2BLK;
            idx_reg       <= '0;
            rem_reg       <= '0;
            st1_reg       <= '0;
        end else begin
            live_lane_reg <= live_lane_next;
            active_reg    <= active_next;
            progress_reg  <= progress_next;
            len_code_reg  <= len_code_next;
            idx_reg       <= idx_next;
            rem_reg       <= rem_next;
            if (en) begin
                st1_reg <= st1_next;
            end
        end
    end

    // Stage 1 payload and coefficient ROM read
    always_ff @(posedge aclk) begin
        if (en) begin
            live1_reg  <= live_lane_reg ? in_b : in_a;
            other1_reg <= live_lane_reg ? in_a : in_b;
            coef1_reg  <= COEF_ROM[rd_addr];
        end
    end

    assign st1    = st1_reg;
    assign live1  = live1_reg;
    assign other1 = other1_reg;
    assign coef1  = coef1_reg;

endmodule

### rtl/core/cos2x_mix.sv
// Mixing datapath: coefficient multiply (stage 2), round and saturate into output register.
`timescale 1ns / 1ps

module cos2x_mix #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  cos2x_pkg::ctl_t                    st1,
    input  logic signed [SAMPLE_BITS-1:0]      live1,
    input  logic signed [SAMPLE_BITS-1:0]      other1,
    input  logic [cos2x_pkg::COEF_BITS-1:0]    coef1,
    output logic                               out_valid,
    output logic signed [SAMPLE_BITS-1:0]      out_sample,
    output logic                               out_fading,
    output logic                               out_done
);
    import cos2x_pkg::*;

    localparam int PW = SAMPLE_BITS + COEF_BITS + 2;
    localparam int QW = PW - COEF_BITS;

    localparam logic signed [QW-1:0] SMAX = QW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [QW-1:0] SMIN = QW'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
    localparam logic signed [PW-1:0] HALF = PW'(64'sd1 <<< (COEF_BITS - 1));

    ctl_t                          st2_reg;
    logic signed [PW-1:0]          sum2_reg, sum2_next;
    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [COEF_BITS:0]     coef_s;
    logic signed [PW-1:0]          prod;

    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg, out_sample_next;
    logic                          out_fading_reg, out_done_reg;
    logic signed [PW-1:0]          rnd;
    logic signed [QW-1:0]          quo;

    // coef*live + (1-coef)*other = coef*(live-other) + other
    assign diff   = (SAMPLE_BITS + 1)'(live1) - (SAMPLE_BITS + 1)'(other1);
    assign coef_s = signed'({1'b0, coef1});
    assign prod   = PW'(coef_s) * PW'(diff);

    // Idle beats carry the live sample scaled by one
    always_comb begin
        if (st1.fading) begin
            sum2_next = prod + (PW'(other1) <<< COEF_BITS);
        end else begin
            sum2_next = PW'(live1) <<< COEF_BITS;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum2_reg <= sum2_next;
        end
    end

    // Round to nearest (ties up), then clamp
    assign rnd = sum2_reg + HALF;
    assign quo = QW'(rnd >>> COEF_BITS);

    always_comb begin
        if (quo > SMAX) begin
            out_sample_next = SMAX[SAMPLE_BITS-1:0];
        end else if (quo < SMIN) begin
            out_sample_next = SMIN[SAMPLE_BITS-1:0];
        end else begin
            out_sample_next = quo[SAMPLE_BITS-1:0];
        end
    end

    // Pipeline valid and flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            st2_reg       <= st1;
            out_valid_reg <= st2_reg.valid;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (en) begin
            out_sample_reg <= out_sample_next;
            out_fading_reg <= st2_reg.fading;
            out_done_reg   <= st2_reg.done;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign out_fading = out_fading_reg;
    assign out_done   = out_done_reg;

endmodule

### rtl/core/cos2_pipeline_crossfader.sv
// Top level of the cosine-squared crossfader between two effect lanes.
`timescale 1ns / 1ps

// Takes one beat per clock while the output register is not stalled, and returns one
// result beat per sample beat through three register stages (sequencer
// with coefficient ROM read, multiply stage, round/saturate into the output
// register); start beats produce no result.
// The whole pipeline advances together whenever the output register is empty
// or being drained, so s_tready follows m_tready through that one gate. While
// idle the live lane passes unchanged; during a fade the output is
// coef*live + (1-coef)*other with coef = cos^2 from a COEF_TABLE_DEPTH-entry
// Q0.16 table, and the live lane flips after the beat flagged fade_done.

module cos2_pipeline_crossfader #(
    parameter int BLOCK_SAMPLES    = 128,
    parameter int COEF_TABLE_DEPTH = 256,
    parameter int SAMPLE_BITS      = 16
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    // input stream
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // [1:0] fade_policy, then lane_a_sample, then lane_b_sample, zero pad
    input  logic [((2*SAMPLE_BITS+2+7)/8)*8-1:0]       s_tdata,
    // [0] op
    input  logic                                       s_tuser,
    // result stream
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // mixed_sample, zero pad
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]           m_tdata,
    // [0] fading, [1] fade_done
    output logic [1:0]                                 m_tuser
);
    import cos2x_pkg::*;

    localparam int OW = ((SAMPLE_BITS + 7) / 8) * 8;

    logic                          en;
    ctl_t                          st1;
    logic signed [SAMPLE_BITS-1:0] live1, other1;
    logic [COEF_BITS-1:0]          coef1;
    logic                          out_valid, out_fading, out_done;
    logic signed [SAMPLE_BITS-1:0] out_sample;

    // Pipeline advances when the output slot is free or being taken
    assign en       = !out_valid || m_tready;
    assign s_tready = en;

    cos2x_ctrl #(
        .BLOCK_SAMPLES   (BLOCK_SAMPLES),
        .COEF_TABLE_DEPTH(COEF_TABLE_DEPTH),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .in_policy(s_tdata[1:0]),
        .in_a     (s_tdata[SAMPLE_BITS+1:2]),
        .in_b     (s_tdata[2*SAMPLE_BITS+1:SAMPLE_BITS+2]),
        .st1      (st1),
        .live1    (live1),
        .other1   (other1),
        .coef1    (coef1)
    );

    cos2x_mix #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .st1       (st1),
        .live1     (live1),
        .other1    (other1),
        .coef1     (coef1),
        .out_valid (out_valid),
        .out_sample(out_sample),
        .out_fading(out_fading),
        .out_done  (out_done)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = OW'(unsigned'(out_sample));
    assign m_tuser  = {out_done, out_fading};

endmodule
